// ===== design/fpgs_pkg.sv =====
// Shared constants, types and rule tables of the fuzzy PID gain scheduler.
// Depends on nothing; every other design file imports it.
package fpgs_pkg;

	localparam int FRAC_BITS  = 12;
	localparam int IN_W       = 16;
	localparam int GAIN_W     = 16;
	localparam int VW         = IN_W + 4;          // room for +/-3.0 while FRAC_BITS <= IN_W + 1
	localparam int WW         = FRAC_BITS + 1;     // weight 0..ONE
	localparam int PW         = 2 * WW;            // weight product
	localparam int TW         = PW + GAIN_W;       // product times level value
	localparam int SW         = TW + 2;            // sum of four terms
	localparam int SEG_W      = 3;
	localparam int CFG_IDX_W  = 4;
	localparam int NUM_LEVELS = 4;
	localparam int NUM_TERMS  = 4;
	localparam int NUM_SETS   = 7;

	typedef logic [SEG_W-1:0]  seg_t;
	typedef logic [WW-1:0]     weight_t;
	typedef logic [PW-1:0]     prod_t;
	typedef logic [1:0]        level_sel_t;
	typedef logic [GAIN_W-1:0] level_val_t;

	typedef level_val_t [NUM_LEVELS-1:0] level_bank_t;
	typedef prod_t      [NUM_TERMS-1:0]  prod_set_t;
	typedef level_sel_t [NUM_TERMS-1:0]  sel_set_t;

	localparam weight_t ONE_W     = WW'(1 << FRAC_BITS);
	localparam seg_t    SEG_FIRST = SEG_W'(0);
	localparam seg_t    SEG_LAST  = SEG_W'(5);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP_LEVEL_ZERO  = 4'd0,
		REG_KP_LEVEL_ONE   = 4'd1,
		REG_KP_LEVEL_TWO   = 4'd2,
		REG_KP_LEVEL_THREE = 4'd3,
		REG_KI_LEVEL_ZERO  = 4'd4,
		REG_KI_LEVEL_ONE   = 4'd5,
		REG_KI_LEVEL_TWO   = 4'd6,
		REG_KI_LEVEL_THREE = 4'd7
	} cfg_idx_t;

	typedef struct packed {
		logic ld_s3;
		logic ld_out;
	} defuzz_ctl_t;

	localparam level_bank_t KP_RESET = {16'd24576, 16'd16384, 16'd8192, 16'd0};
	localparam level_bank_t KI_RESET = {16'd41943, 16'd20972, 16'd10486, 16'd0};

	// rows: error set, columns: error-change set
	localparam level_sel_t KP_TABLE [NUM_SETS][NUM_SETS] = '{
		'{2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3},
		'{2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd2, 2'd2},
		'{2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1},
		'{2'd1, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1},
		'{2'd0, 2'd0, 2'd1, 2'd0, 2'd0, 2'd1, 2'd0},
		'{2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd0, 2'd2},
		'{2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3}
	};

	localparam level_sel_t KI_TABLE [NUM_SETS][NUM_SETS] = '{
		'{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1},
		'{2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3}
	};

endpackage

// ===== design/fuzzy_pid_gain_scheduler.sv =====
// Fuzzy PID gain scheduler: takes a word of error and error change (signed Q3.12) and
// returns a word of kp and ki gains from a 7x7 rule base with weighted-average
// defuzzification. The pipeline has four register stages (fuzzify, weight products,
// level multiply, sum), and a new word can be accepted every cycle while in_stall is
// low. Each stage holds its word while the next one is full and stalled; in_stall rises
// only when all four stages hold words and out_stall is high. Level values are written
// over the cfg port, which is always ready; write them only while no word is in flight.
// Depends on fpgs_pkg, fpgs_fuzzify, fpgs_cfg_regs, fpgs_rules and fpgs_defuzz.
module fuzzy_pid_gain_scheduler (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [fpgs_pkg::IN_W-1:0] error_value,
	input  logic signed [fpgs_pkg::IN_W-1:0] error_change,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [fpgs_pkg::GAIN_W-1:0]    kp_gain,
	output logic [fpgs_pkg::GAIN_W-1:0]    ki_gain,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fpgs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fpgs_pkg::GAIN_W-1:0]    cfg_data
);
	import fpgs_pkg::*;

	localparam logic [PW+1:0] ONE_SQ = (PW+2)'(1) << (2 * FRAC_BITS);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;
	logic ld_s1, ld_s2;
	defuzz_ctl_t dctl;

	seg_t    seg_e, seg_c;
	weight_t wl_e, wl_c;
	seg_t    seg_e_s1, seg_c_s1;
	weight_t wl_e_s1, wl_c_s1;

	prod_set_t   w_s2;
	sel_set_t    kp_sel_s2, ki_sel_s2;
	level_bank_t kp_bank, ki_bank;
	logic [PW+1:0] wsum_s2;

	// a stage may load when it is empty or its word moves on this cycle
	assign en4 = !v_s4 || !out_stall;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign in_stall    = !en1;
	assign ld_s1       = en1 && in_valid;
	assign ld_s2       = en2 && v_s1;
	assign dctl.ld_s3  = en3 && v_s2;
	assign dctl.ld_out = en4 && v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	fpgs_fuzzify u_fuzz_e (
		.value (error_value),
		.seg   (seg_e),
		.wl    (wl_e)
	);

	fpgs_fuzzify u_fuzz_c (
		.value (error_change),
		.seg   (seg_c),
		.wl    (wl_c)
	);

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			seg_e_s1 <= seg_e;
			seg_c_s1 <= seg_c;
			wl_e_s1  <= wl_e;
			wl_c_s1  <= wl_c;
		end
	end

	fpgs_rules u_rules (
		.clk       (clk),
		.ld        (ld_s2),
		.seg_e     (seg_e_s1),
		.seg_c     (seg_c_s1),
		.wl_e      (wl_e_s1),
		.wl_c      (wl_c_s1),
		.w_s2      (w_s2),
		.kp_sel_s2 (kp_sel_s2),
		.ki_sel_s2 (ki_sel_s2)
	);

	fpgs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.kp_bank   (kp_bank),
		.ki_bank   (ki_bank)
	);

	fpgs_defuzz u_defuzz (
		.clk        (clk),
		.ctl        (dctl),
		.w_s2       (w_s2),
		.kp_sel_s2  (kp_sel_s2),
		.ki_sel_s2  (ki_sel_s2),
		.kp_bank    (kp_bank),
		.ki_bank    (ki_bank),
		.kp_gain_s4 (kp_gain),
		.ki_gain_s4 (ki_gain)
	);

	assign out_valid = v_s4;
	assign cfg_ready = 1'b1;

	assign wsum_s2 = (PW+2)'(w_s2[0]) + (PW+2)'(w_s2[1])
	               + (PW+2)'(w_s2[2]) + (PW+2)'(w_s2[3]);

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && out_stall))
		else $error("input stalled while the pipeline has room");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted word missing from stage 1");

	a_weights_partition: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (wsum_s2 == ONE_SQ))
		else $error("rule weights do not sum to one");

	a_cfg_kp0_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && (cfg_index == REG_KP_LEVEL_ZERO))
		|=> (kp_bank[0] == $past(cfg_data)))
		else $error("kp level zero write lost");

endmodule

// ===== design/fpgs_fuzzify.sv =====
// Fuzzifier for one Q3.12 input: segment index and lower weight.
// Depends on fpgs_pkg.
module fpgs_fuzzify (
	input  logic signed [fpgs_pkg::IN_W-1:0] value,
	output fpgs_pkg::seg_t                   seg,
	output fpgs_pkg::weight_t                wl
);
	import fpgs_pkg::*;

	localparam logic signed [VW-1:0] POS3 = VW'(3 * (1 << FRAC_BITS));
	localparam logic signed [VW-1:0] NEG3 = -POS3;

	logic signed [VW-1:0] vx;
	logic        [VW-1:0] u;

	assign vx = VW'(value);
	assign u  = vx + POS3;

	// inside the range the lower weight is ONE minus the fraction past the breakpoint
	always_comb begin
		if (vx < NEG3) begin
			seg = SEG_FIRST;
			wl  = ONE_W;
		end else if (vx >= POS3) begin
			seg = SEG_LAST;
			wl  = '0;
		end else begin
			seg = u[FRAC_BITS +: SEG_W];
			wl  = ONE_W - {1'b0, u[FRAC_BITS-1:0]};
		end
	end

endmodule

// ===== design/fpgs_cfg_regs.sv =====
// Level value registers for kp and ki, written over the configuration port.
// Depends on fpgs_pkg.
module fpgs_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [fpgs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fpgs_pkg::GAIN_W-1:0]    cfg_data,
	output fpgs_pkg::level_bank_t          kp_bank,
	output fpgs_pkg::level_bank_t          ki_bank
);
	import fpgs_pkg::*;

	level_bank_t kp_bank_q;
	level_bank_t ki_bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_bank_q <= KP_RESET;
			ki_bank_q <= KI_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_KP_LEVEL_ZERO:  kp_bank_q[0] <= cfg_data;
				REG_KP_LEVEL_ONE:   kp_bank_q[1] <= cfg_data;
				REG_KP_LEVEL_TWO:   kp_bank_q[2] <= cfg_data;
				REG_KP_LEVEL_THREE: kp_bank_q[3] <= cfg_data;
				REG_KI_LEVEL_ZERO:  ki_bank_q[0] <= cfg_data;
				REG_KI_LEVEL_ONE:   ki_bank_q[1] <= cfg_data;
				REG_KI_LEVEL_TWO:   ki_bank_q[2] <= cfg_data;
				REG_KI_LEVEL_THREE: ki_bank_q[3] <= cfg_data;
				default: ;  // unmapped index, dropped
			endcase
		end
	end

	assign kp_bank = kp_bank_q;
	assign ki_bank = ki_bank_q;

endmodule

// ===== design/fpgs_rules.sv =====
// Stage 2: weight products of the four active rules and their table levels.
// Depends on fpgs_pkg.
module fpgs_rules (
	input  logic              clk,
	input  logic              ld,
	input  fpgs_pkg::seg_t    seg_e,
	input  fpgs_pkg::seg_t    seg_c,
	input  fpgs_pkg::weight_t wl_e,
	input  fpgs_pkg::weight_t wl_c,
	output fpgs_pkg::prod_set_t w_s2,
	output fpgs_pkg::sel_set_t  kp_sel_s2,
	output fpgs_pkg::sel_set_t  ki_sel_s2
);
	import fpgs_pkg::*;

	weight_t   we [2];
	weight_t   wc [2];
	prod_set_t w_d;
	sel_set_t  kp_sel_d;
	sel_set_t  ki_sel_d;

	assign we[0] = wl_e;
	assign we[1] = ONE_W - wl_e;
	assign wc[0] = wl_c;
	assign wc[1] = ONE_W - wl_c;

	// term index = 2*a + b, a steps the error set, b the change set
	always_comb begin
		seg_t row;
		seg_t col;
		for (int a = 0; a < 2; a++) begin
			for (int b = 0; b < 2; b++) begin
				row = seg_e + SEG_W'(a);
				col = seg_c + SEG_W'(b);
				w_d[2*a+b]      = PW'(we[a]) * PW'(wc[b]);
				kp_sel_d[2*a+b] = KP_TABLE[row][col];
				ki_sel_d[2*a+b] = KI_TABLE[row][col];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			w_s2      <= w_d;
			kp_sel_s2 <= kp_sel_d;
			ki_sel_s2 <= ki_sel_d;
		end
	end

endmodule

// ===== design/fpgs_defuzz.sv =====
// Stages 3 and 4: rule terms times level values, then the weighted sum.
// Depends on fpgs_pkg.
module fpgs_defuzz (
	input  logic                        clk,
	input  fpgs_pkg::defuzz_ctl_t       ctl,
	input  fpgs_pkg::prod_set_t         w_s2,
	input  fpgs_pkg::sel_set_t          kp_sel_s2,
	input  fpgs_pkg::sel_set_t          ki_sel_s2,
	input  fpgs_pkg::level_bank_t       kp_bank,
	input  fpgs_pkg::level_bank_t       ki_bank,
	output logic [fpgs_pkg::GAIN_W-1:0] kp_gain_s4,
	output logic [fpgs_pkg::GAIN_W-1:0] ki_gain_s4
);
	import fpgs_pkg::*;

	logic [TW-1:0] kp_term_s3 [NUM_TERMS];
	logic [TW-1:0] ki_term_s3 [NUM_TERMS];
	logic [SW-1:0] kp_sum;
	logic [SW-1:0] ki_sum;

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			for (int i = 0; i < NUM_TERMS; i++) begin
				kp_term_s3[i] <= TW'(w_s2[i]) * TW'(kp_bank[kp_sel_s2[i]]);
				ki_term_s3[i] <= TW'(w_s2[i]) * TW'(ki_bank[ki_sel_s2[i]]);
			end
		end
	end

	always_comb begin
		kp_sum = '0;
		ki_sum = '0;
		for (int i = 0; i < NUM_TERMS; i++) begin
			kp_sum = kp_sum + SW'(kp_term_s3[i]);
			ki_sum = ki_sum + SW'(ki_term_s3[i]);
		end
	end

	// weights sum to ONE^2, so dropping 2*FRAC_BITS leaves the gain in level units
	always_ff @(posedge clk) begin
		if (ctl.ld_out) begin
			kp_gain_s4 <= kp_sum[2*FRAC_BITS +: GAIN_W];
			ki_gain_s4 <= ki_sum[2*FRAC_BITS +: GAIN_W];
		end
	end

endmodule
